[rtl/liferle_pkg.sv]
package liferle_pkg;

	localparam int unsigned MAX_DIM   = 4096;
	localparam int unsigned COUNT_MAX = 65535;

	localparam int unsigned SYM_W   = 8;
	localparam int unsigned CFG_W   = 13;
	localparam int unsigned ROW_W   = 12;
	localparam int unsigned COL_W   = 17;
	localparam int unsigned ADDR_W  = 24;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned COUNT_W = $clog2(COUNT_MAX + 1);

	// working widths for sums and compares
	localparam int unsigned SUM_W  = ((COL_W > COUNT_W) ? COL_W : COUNT_W) + 1;
	localparam int unsigned PROD_W = COUNT_W + 4;
	localparam int unsigned LCMP_W = (COUNT_W > LEN_W) ? COUNT_W : LEN_W;

	localparam int unsigned ROW_LIMIT = ((MAX_DIM - 1) < 4095) ? (MAX_DIM - 1) : 4095;
	localparam logic [ROW_W-1:0]  ROW_CAP  = ROW_W'(ROW_LIMIT);
	localparam logic [COL_W-1:0]  COL_CAP  = '1;
	localparam logic [ADDR_W-1:0] ADDR_CAP = '1;
	localparam logic [LEN_W-1:0]  LEN_CAP  = '1;

	localparam logic [CFG_W-1:0] ROW_STRIDE_RESET = CFG_W'(64);
	localparam logic [CFG_W-1:0] ROW_COUNT_RESET  = CFG_W'(64);

	localparam logic [SYM_W-1:0] SYM_ZERO   = 8'h30;
	localparam logic [SYM_W-1:0] SYM_NINE   = 8'h39;
	localparam logic [SYM_W-1:0] SYM_DEAD   = 8'h62;
	localparam logic [SYM_W-1:0] SYM_LIVE   = 8'h6f;
	localparam logic [SYM_W-1:0] SYM_EOL    = 8'h24;
	localparam logic [SYM_W-1:0] SYM_END    = 8'h21;

	typedef logic [0:0] cfg_index_t;
	localparam cfg_index_t REG_ROW_STRIDE = 1'b0;
	localparam cfg_index_t REG_ROW_COUNT  = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] cell_address;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  column;
		logic [LEN_W-1:0]  run_length;
		logic              out_of_range;
		logic              done_res;
	} result_t;

endpackage

[rtl/liferle_in_if.sv]
interface liferle_in_if;

	logic                           valid;
	logic                           ready;
	logic [liferle_pkg::SYM_W-1:0]  symbol;
	logic                           first;

	modport source (output valid, output symbol, output first, input ready);
	modport sink (input valid, input symbol, input first, output ready);

endinterface

[rtl/liferle_out_if.sv]
interface liferle_out_if;

	logic                            valid;
	logic                            ready;
	logic [liferle_pkg::ADDR_W-1:0]  cell_address;
	logic [liferle_pkg::ROW_W-1:0]   row;
	logic [liferle_pkg::COL_W-1:0]   column;
	logic [liferle_pkg::LEN_W-1:0]   run_length;
	logic                            out_of_range;
	logic                            done_res;

	modport source (
		output valid, output cell_address, output row, output column,
		output run_length, output out_of_range, output done_res, input ready
	);
	modport sink (
		input valid, input cell_address, input row, input column,
		input run_length, input out_of_range, input done_res, output ready
	);

endinterface

[rtl/liferle_decode.sv]
module liferle_decode (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic [liferle_pkg::SYM_W-1:0]     symbol,
	input  logic                              first,
	input  logic [liferle_pkg::CFG_W-1:0]     row_stride,
	input  logic [liferle_pkg::CFG_W-1:0]     row_count,
	output logic                              has_res,
	output liferle_pkg::result_t              res
);

	logic [liferle_pkg::ROW_W-1:0]   row_q, row_d, row_e;
	logic [liferle_pkg::COL_W-1:0]   col_q, col_d, col_e;
	logic [liferle_pkg::ADDR_W-1:0]  base_q, base_d, base_e;
	logic [liferle_pkg::COUNT_W-1:0] pend_q, pend_d, pend_e;
	logic                            present_q, present_d, present_e;
	logic                            finished_q, finished_d, finished_e;
	logic                            rovf_q, rovf_d, rovf_e;

	logic [liferle_pkg::COUNT_W-1:0] n;
	logic [liferle_pkg::PROD_W-1:0]  prod;
	logic [liferle_pkg::SUM_W-1:0]   col_sum;
	logic [liferle_pkg::COL_W-1:0]   col_adv;
	logic [liferle_pkg::ADDR_W:0]    addr_sum;
	logic [liferle_pkg::ADDR_W:0]    base_sum;
	logic                            is_digit;

	// first byte of a pattern sees cleared state
	always_comb begin
		row_e      = first ? '0 : row_q;
		col_e      = first ? '0 : col_q;
		base_e     = first ? '0 : base_q;
		pend_e     = first ? '0 : pend_q;
		present_e  = first ? 1'b0 : present_q;
		finished_e = first ? 1'b0 : finished_q;
		rovf_e     = first ? 1'b0 : rovf_q;
	end

	always_comb begin
		is_digit = (symbol >= liferle_pkg::SYM_ZERO) && (symbol <= liferle_pkg::SYM_NINE);
		n        = present_e ? pend_e : liferle_pkg::COUNT_W'(1);
		prod     = (liferle_pkg::PROD_W'(pend_e) << 3) + (liferle_pkg::PROD_W'(pend_e) << 1)
		         + liferle_pkg::PROD_W'(symbol - liferle_pkg::SYM_ZERO);
		col_sum  = liferle_pkg::SUM_W'(col_e) + liferle_pkg::SUM_W'(n);
		col_adv  = (col_sum > liferle_pkg::SUM_W'(liferle_pkg::COL_CAP))
		         ? liferle_pkg::COL_CAP : col_sum[liferle_pkg::COL_W-1:0];
		addr_sum = (liferle_pkg::ADDR_W+1)'(base_e) + (liferle_pkg::ADDR_W+1)'(col_e);
		base_sum = (liferle_pkg::ADDR_W+1)'(base_e) + (liferle_pkg::ADDR_W+1)'(row_stride);
	end

	always_comb begin
		row_d      = row_e;
		col_d      = col_e;
		base_d     = base_e;
		pend_d     = pend_e;
		present_d  = present_e;
		finished_d = finished_e;
		rovf_d     = rovf_e;
		has_res    = 1'b0;
		res        = '0;
		if (!finished_e) begin
			if (is_digit) begin
				pend_d    = (prod > liferle_pkg::PROD_W'(liferle_pkg::COUNT_MAX))
				          ? liferle_pkg::COUNT_W'(liferle_pkg::COUNT_MAX)
				          : prod[liferle_pkg::COUNT_W-1:0];
				present_d = 1'b1;
			end else begin
				unique case (symbol)
					liferle_pkg::SYM_DEAD: begin
						pend_d    = '0;
						present_d = 1'b0;
						col_d     = col_adv;
					end
					liferle_pkg::SYM_LIVE: begin
						pend_d           = '0;
						present_d        = 1'b0;
						col_d            = col_adv;
						has_res          = 1'b1;
						res.cell_address = addr_sum[liferle_pkg::ADDR_W]
						                 ? liferle_pkg::ADDR_CAP
						                 : addr_sum[liferle_pkg::ADDR_W-1:0];
						res.row          = row_e;
						res.column       = col_e;
						res.run_length   = (liferle_pkg::LCMP_W'(n)
						                 > liferle_pkg::LCMP_W'(liferle_pkg::LEN_CAP))
						                 ? liferle_pkg::LEN_CAP : liferle_pkg::LEN_W'(n);
						res.out_of_range = rovf_e
						                 || ({1'b0, row_e} >= row_count)
						                 || (col_sum > liferle_pkg::SUM_W'(row_stride));
					end
					liferle_pkg::SYM_EOL: begin
						pend_d    = '0;
						present_d = 1'b0;
						col_d     = '0;
						if (row_e >= liferle_pkg::ROW_CAP) begin
							rovf_d = 1'b1;
						end else begin
							row_d  = row_e + liferle_pkg::ROW_W'(1);
							base_d = base_sum[liferle_pkg::ADDR_W]
							       ? liferle_pkg::ADDR_CAP
							       : base_sum[liferle_pkg::ADDR_W-1:0];
						end
					end
					liferle_pkg::SYM_END: begin
						pend_d       = '0;
						present_d    = 1'b0;
						finished_d   = 1'b1;
						has_res      = 1'b1;
						res.done_res = 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			base_q     <= '0;
			pend_q     <= '0;
			present_q  <= 1'b0;
			finished_q <= 1'b0;
			rovf_q     <= 1'b0;
		end else if (advance) begin
			row_q      <= row_d;
			col_q      <= col_d;
			base_q     <= base_d;
			pend_q     <= pend_d;
			present_q  <= present_d;
			finished_q <= finished_d;
			rovf_q     <= rovf_d;
		end
	end

endmodule

[rtl/life_rle_pattern_decoder_core.sv]
// Run-length pattern body decoder for a cellular-automaton board.
// pattern: input channel, one word per byte of the pattern body (symbol, first).
//   first marks the first byte of a new pattern and clears the decoder state.
// runs: output channel, one word per 'o' (a run of live cells with its address,
//   row, column, length and range flag) and one word with done_res for '!'.
// cfg_we / cfg_index / cfg_data: register writes, index 0 row_stride,
//   index 1 row_count; write only while no byte is in flight.
// Throughput: one byte per cycle while runs is not stalled, set by the single
//   decode stage between the input register and the result register.
// A byte accepted into the input register is decoded there; its result word is
//   loaded into the result register, which drives runs.
// Reset clears the decoder state and both channels; row_stride and row_count
//   return to 64.
// A stalled receiver holds the result register; one more byte is taken into
//   the input register, and bytes that give no result keep flowing.
module life_rle_pattern_decoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	liferle_in_if.sink                    pattern,
	liferle_out_if.source                 runs,
	input  logic                          cfg_we,
	input  liferle_pkg::cfg_index_t       cfg_index,
	input  logic [liferle_pkg::CFG_W-1:0] cfg_data
);

	logic                           valid_s1;
	logic [liferle_pkg::SYM_W-1:0]  symbol_s1;
	logic                           first_s1;
	logic [liferle_pkg::CFG_W-1:0]  row_stride_q;
	logic [liferle_pkg::CFG_W-1:0]  row_count_q;
	logic                           out_valid_q;
	liferle_pkg::result_t           res_q;
	liferle_pkg::result_t           res;
	logic                           has_res;
	logic                           advance;

	assign advance       = valid_s1 && (!out_valid_q || runs.ready || !has_res);
	assign pattern.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_stride_q <= liferle_pkg::ROW_STRIDE_RESET;
			row_count_q  <= liferle_pkg::ROW_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				liferle_pkg::REG_ROW_STRIDE: row_stride_q <= cfg_data;
				liferle_pkg::REG_ROW_COUNT:  row_count_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pattern.valid && pattern.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pattern.valid && pattern.ready) begin
			symbol_s1 <= pattern.symbol;
			first_s1  <= pattern.first;
		end
	end

	liferle_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.symbol     (symbol_s1),
		.first      (first_s1),
		.row_stride (row_stride_q),
		.row_count  (row_count_q),
		.has_res    (has_res),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_res) begin
			out_valid_q <= 1'b1;
		end else if (runs.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			res_q <= res;
		end
	end

	assign runs.valid        = out_valid_q;
	assign runs.cell_address = res_q.cell_address;
	assign runs.row          = res_q.row;
	assign runs.column       = res_q.column;
	assign runs.run_length   = res_q.run_length;
	assign runs.out_of_range = res_q.out_of_range;
	assign runs.done_res     = res_q.done_res;

	// an empty input register always takes a word
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> pattern.ready)
		else $error("input register empty but not ready");

	// a decoded result lands in the result register
	a_res_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance && has_res |=> out_valid_q)
		else $error("decoded result not registered");

	// end-of-pattern word carries no run
	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		runs.valid && runs.done_res |->
			runs.run_length == '0 && runs.cell_address == '0 && !runs.out_of_range)
		else $error("done word with run payload");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !runs.ready |-> !(advance && has_res))
		else $error("result register overwritten while stalled");

endmodule
